// ===== rtl/pgfb_pkg.sv =====
// Package for the page framebuffer text renderer.
// Holds command, status, register index and state codes and the item structs.
// No dependencies.
package pgfb_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_FONT  = 3'd0,
    CMD_SET_CURSOR = 3'd1,
    CMD_DRAW_PIXEL = 3'd2,
    CMD_WRITE_CHAR = 3'd3,
    CMD_FILL       = 3'd4,
    CMD_READ_BYTE  = 3'd5
  } pgfb_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_CTRL_CODE = 2'd2
  } pgfb_status_t;

  typedef enum logic [1:0] {
    REG_INVERT      = 2'd0,
    REG_FONT_WIDTH  = 2'd1,
    REG_FONT_HEIGHT = 2'd2
  } pgfb_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_ROW_LOAD,
    S_COL,
    S_PIX_WR,
    S_FILL,
    S_READ,
    S_DONE
  } pgfb_state_t;

  typedef struct packed {
    logic       invert;
    logic [4:0] font_width;
    logic [4:0] font_height;
  } pgfb_cfg_t;

  typedef struct packed {
    logic [9:0]  fb_addr;
    logic [15:0] font_row;
    logic [11:0] font_addr;
    logic [7:0]  char_code;
    logic        color;
    logic [7:0]  pos_y;
    logic [7:0]  pos_x;
    pgfb_cmd_t   command;
  } pgfb_item_t;

  typedef struct packed {
    logic [7:0]   read_data;
    pgfb_status_t status;
  } pgfb_res_t;

  localparam int unsigned GLYPH_HI_CODE = 192;
  localparam int unsigned GLYPH_HI_OFS  = 191;
  localparam int unsigned GLYPH_LO_OFS  = 32;
  localparam int unsigned MAX_COLS      = 16;

endpackage

// ===== rtl/pgfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pgfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pgfb_engine.sv =====
// Command sequencer for the page framebuffer: frame and font memories with
// read-modify-write pixel updates, glyph walk, fill and clear sweeps.
// Depends on pgfb_pkg and pgfb_ram.
module pgfb_engine #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned FONT_ROWS     = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pgfb_pkg::pgfb_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pgfb_pkg::pgfb_item_t in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output pgfb_pkg::pgfb_res_t  res
);
  import pgfb_pkg::*;

  localparam int unsigned FB_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int unsigned FB_AW    = $clog2(FB_BYTES);
  localparam int unsigned FONT_AW  = $clog2(FONT_ROWS);

  pgfb_state_t        state_r, state_nxt;
  pgfb_item_t         item_r, item_nxt;
  pgfb_res_t          res_r, res_nxt;
  logic [7:0]         cx_r, cx_nxt;
  logic [7:0]         cy_r, cy_nxt;
  logic [12:0]        row_addr_r, row_addr_nxt;
  logic [4:0]         row_i_r, row_i_nxt;
  logic [4:0]         col_r, col_nxt;
  logic [15:0]        bits_r, bits_nxt;
  logic [FB_AW-1:0]   pix_addr_r, pix_addr_nxt;
  logic [2:0]         pix_bit_r, pix_bit_nxt;
  logic               color_eff_r, color_eff_nxt;
  logic [FB_AW-1:0]   sweep_r, sweep_nxt;
  logic [7:0]         fill_val_r, fill_val_nxt;

  logic               fb_we, fb_re;
  logic [FB_AW-1:0]   fb_waddr, fb_raddr;
  logic [7:0]         fb_wdata, fb_rdata;
  logic               font_we, font_re;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic [15:0]        font_rdata;

  logic [7:0]         pix_x, pix_y;
  logic [12:0]        pix_lin;
  logic [FB_AW-1:0]   pix_addr;
  logic [7:0]         pix_mask;
  logic               on_screen;
  logic               no_room;
  logic [7:0]         glyph;
  logic [13:0]        row_next14;
  logic [12:0]        row_next;
  logic [12:0]        rd_lin;
  logic [13:0]        faddr14;
  logic               row_end;

  pgfb_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_frame_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .re    (fb_re),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  pgfb_ram #(.WIDTH(16), .DEPTH(FONT_ROWS)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (item_r.font_row),
    .re    (font_re),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  always_comb begin
    if (state_r == S_COL) begin
      pix_x = 8'(cx_r + 8'(col_r));
      pix_y = 8'(cy_r + 8'(row_i_r));
    end else begin
      pix_x = item_r.pos_x;
      pix_y = item_r.pos_y;
    end
    pix_lin    = 13'(pix_x) + 13'(pix_y[7:3]) * 13'(SCREEN_WIDTH);
    pix_addr   = pix_lin[FB_AW-1:0];
    pix_mask   = 8'(1) << pix_bit_r;
    on_screen  = ({1'b0, item_r.pos_x} < 9'(SCREEN_WIDTH)) &&
                 ({1'b0, item_r.pos_y} < 9'(SCREEN_HEIGHT));
    no_room    = (9'(cx_r) + 9'(cfg.font_width) >= 9'(SCREEN_WIDTH)) ||
                 (9'(cy_r) + 9'(cfg.font_height) >= 9'(SCREEN_HEIGHT));
    glyph      = (item_r.char_code >= 8'(GLYPH_HI_CODE)) ?
                 8'(item_r.char_code - 8'(GLYPH_HI_OFS)) :
                 8'(item_r.char_code - 8'(GLYPH_LO_OFS));
    row_next14 = 14'(row_addr_r) + 14'd1;
    row_next   = (row_next14 == 14'(FONT_ROWS)) ? 13'd0 : row_next14[12:0];
    rd_lin     = 13'(item_r.fb_addr);
    faddr14    = 14'(item_r.font_addr);
    row_end    = (col_r == 5'(MAX_COLS)) || (col_r >= cfg.font_width);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    row_addr_nxt  = row_addr_r;
    row_i_nxt     = row_i_r;
    col_nxt       = col_r;
    bits_nxt      = bits_r;
    pix_addr_nxt  = pix_addr_r;
    pix_bit_nxt   = pix_bit_r;
    color_eff_nxt = color_eff_r;
    sweep_nxt     = sweep_r;
    fill_val_nxt  = fill_val_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    fb_we         = 1'b0;
    fb_waddr      = pix_addr_r;
    fb_wdata      = fill_val_r;
    fb_re         = 1'b0;
    fb_raddr      = pix_addr;
    font_we       = 1'b0;
    font_waddr    = faddr14[FONT_AW-1:0];
    font_re       = 1'b0;
    font_raddr    = row_addr_r[FONT_AW-1:0];

    case (state_r)
      S_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = sweep_r;
        fb_wdata = 8'h00;
        if (sweep_r == FB_AW'(FB_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + FB_AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_item;
          res_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        color_eff_nxt = item_r.color ^ cfg.invert;
        state_nxt     = S_DONE;
        case (item_r.command)
          CMD_LOAD_FONT: begin
            font_we = (faddr14 < 14'(FONT_ROWS));
          end
          CMD_SET_CURSOR: begin
            cx_nxt = item_r.pos_x;
            cy_nxt = item_r.pos_y;
          end
          CMD_DRAW_PIXEL: begin
            if (on_screen) begin
              fb_re        = 1'b1;
              pix_addr_nxt = pix_addr;
              pix_bit_nxt  = pix_y[2:0];
              state_nxt    = S_PIX_WR;
            end
          end
          CMD_WRITE_CHAR: begin
            if (no_room) begin
              res_nxt.status = ST_NO_ROOM;
            end else if (item_r.char_code < 8'(GLYPH_LO_OFS)) begin
              res_nxt.status = ST_CTRL_CODE;
            end else begin
              row_addr_nxt = 13'(glyph) * 13'(cfg.font_height);
              state_nxt    = S_MOD;
            end
          end
          CMD_FILL: begin
            sweep_nxt    = '0;
            fill_val_nxt = item_r.color ? 8'hFF : 8'h00;
            state_nxt    = S_FILL;
          end
          CMD_READ_BYTE: begin
            if (rd_lin < 13'(FB_BYTES)) begin
              fb_re     = 1'b1;
              fb_raddr  = rd_lin[FB_AW-1:0];
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MOD: begin
        if (14'(row_addr_r) >= 14'(FONT_ROWS)) begin
          row_addr_nxt = 13'(14'(row_addr_r) - 14'(FONT_ROWS));
        end else if (cfg.font_height == 5'd0) begin
          cx_nxt    = 8'(cx_r + 8'(cfg.font_width));
          state_nxt = S_DONE;
        end else begin
          font_re   = 1'b1;
          row_i_nxt = '0;
          state_nxt = S_ROW_LOAD;
        end
      end
      S_ROW_LOAD: begin
        bits_nxt  = font_rdata;
        col_nxt   = '0;
        state_nxt = S_COL;
      end
      S_COL: begin
        if (row_end) begin
          if (5'(row_i_r + 5'd1) == cfg.font_height) begin
            cx_nxt    = 8'(cx_r + 8'(cfg.font_width));
            state_nxt = S_DONE;
          end else begin
            row_i_nxt    = 5'(row_i_r + 5'd1);
            row_addr_nxt = row_next;
            font_re      = 1'b1;
            font_raddr   = row_next[FONT_AW-1:0];
            state_nxt    = S_ROW_LOAD;
          end
        end else begin
          bits_nxt = {bits_r[14:0], 1'b0};
          col_nxt  = 5'(col_r + 5'd1);
          if (bits_r[15]) begin
            fb_re        = 1'b1;
            pix_addr_nxt = pix_addr;
            pix_bit_nxt  = pix_y[2:0];
            state_nxt    = S_PIX_WR;
          end
        end
      end
      S_PIX_WR: begin
        fb_we     = 1'b1;
        fb_wdata  = color_eff_r ? (fb_rdata | pix_mask) : (fb_rdata & ~pix_mask);
        state_nxt = (item_r.command == CMD_WRITE_CHAR) ? S_COL : S_DONE;
      end
      S_FILL: begin
        fb_we    = 1'b1;
        fb_waddr = sweep_r;
        if (sweep_r == FB_AW'(FB_BYTES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + FB_AW'(1);
        end
      end
      S_READ: begin
        res_nxt.read_data = fb_rdata;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cx_r       <= '0;
      cy_r       <= '0;
      sweep_r    <= '0;
      fill_val_r <= 8'h00;
    end else begin
      state_r    <= state_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      sweep_r    <= sweep_nxt;
      fill_val_r <= fill_val_nxt;
    end
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    row_addr_r  <= row_addr_nxt;
    row_i_r     <= row_i_nxt;
    col_r       <= col_nxt;
    bits_r      <= bits_nxt;
    pix_addr_r  <= pix_addr_nxt;
    pix_bit_r   <= pix_bit_nxt;
    color_eff_r <= color_eff_nxt;
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_fb_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(fb_we && fb_re))
    else $error("frame read and write in the same cycle");

  a_fb_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    fb_we |-> (13'(fb_waddr) < 13'(FB_BYTES)))
    else $error("frame write beyond the store");

  a_row_addr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL) |-> (14'(row_addr_r) < 14'(FONT_ROWS)))
    else $error("font row address not reduced");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL) |-> (col_r <= 5'(MAX_COLS)))
    else $error("column counter past row width");

  a_pix_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX_WR) |-> $past(fb_re))
    else $error("pixel write without a preceding frame read");
`endif

endmodule

// ===== rtl/page_framebuffer_text_render.sv =====
// Page framebuffer text renderer top level. A write char reduces the glyph base in steps,
// then for each glyph row loads the font row and walks W' = min(font_width,16) columns;
// each set bit drawn is a read-modify-write on the frame memory port. One item at a time.
// Reset (rst_n, synchronous) resets the cursor, state and configuration registers, then a clearing pass writes
// zero to all FB_BYTES frame bytes, one per cycle, before the first item is taken.
module page_framebuffer_text_render #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned FONT_ROWS     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], pos_x[10:3], pos_y[18:11], color[19], char_code[27:20],
  // font_addr[39:28], font_row[55:40], fb_addr[65:56], zero[71:66]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], read_data[9:2], zero[15:10]
  output logic [15:0] out_tdata
);
  import pgfb_pkg::*;

  pgfb_cfg_t  cfg_r;
  pgfb_item_t in_item;
  pgfb_res_t  res;
  pgfb_res_t  out_res_r;
  logic       out_valid_r;
  logic       res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert      <= 1'b0;
      cfg_r.font_width  <= 5'd7;
      cfg_r.font_height <= 5'd10;
    end else if (cfg_we) begin
      case (pgfb_reg_t'(cfg_index))
        REG_INVERT:      cfg_r.invert      <= cfg_wdata[0];
        REG_FONT_WIDTH:  cfg_r.font_width  <= cfg_wdata;
        REG_FONT_HEIGHT: cfg_r.font_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_item.command   = pgfb_cmd_t'(in_tdata[2:0]);
  assign in_item.pos_x     = in_tdata[10:3];
  assign in_item.pos_y     = in_tdata[18:11];
  assign in_item.color     = in_tdata[19];
  assign in_item.char_code = in_tdata[27:20];
  assign in_item.font_addr = in_tdata[39:28];
  assign in_item.font_row  = in_tdata[55:40];
  assign in_item.fb_addr   = in_tdata[65:56];

  pgfb_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FONT_ROWS     (FONT_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.read_data, out_res_r.status};

endmodule
